/* hw/rtl/polyline_coordinate_encoder_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the polyline coordinate encoder
// Concurrent checks clocked on clk and disabled while rst_n is low.
// They compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef POLYLINE_COORDINATE_ENCODER_TOP_ASSERT_SVH
`define POLYLINE_COORDINATE_ENCODER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Check that a property holds at every clock edge out of reset
`define PCE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds at a clock edge out of reset
`define PCE_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define PCE_ASSERT(label, prop, msg)
`define PCE_ASSERT_NEVER(label, cond, msg)

`endif

`endif

/* hw/rtl/pce_pkg.sv */
// ----------------------------------------------------------------------------
// pce_pkg
// Shared constants and controller/datapath command types for the encoder.
// ----------------------------------------------------------------------------
package pce_pkg;

    // Character stream format
    localparam int unsigned CHUNK_BITS = 5;
    localparam int unsigned MAX_CHARS  = 6;
    localparam int unsigned ZZ_BITS    = CHUNK_BITS * MAX_CHARS;
    localparam int unsigned CHAR_BITS  = 7;
    localparam int unsigned EXT_BITS   = 64;

    localparam logic [CHAR_BITS-1:0] CHAR_OFFSET = 7'd63;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;   // take a new coordinate, form the zigzag delta
        logic shift;  // drop the chunk just delivered
    } pce_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic last;   // current chunk is the final one of this coordinate
    } pce_status_t;

endpackage

/* hw/rtl/pce_datapath.sv */
// ----------------------------------------------------------------------------
// pce_datapath
// Holds previous latitude/longitude, forms the zigzag delta and shifts it
// out five bits at a time as printable characters.
// ----------------------------------------------------------------------------
module pce_datapath
    import pce_pkg::*;
#(
    parameter int unsigned COORD_BITS = 26
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  pce_cmd_t                    cmd,
    output pce_status_t                 status,
    input  logic signed [COORD_BITS-1:0] coordinate,
    input  logic                        axis,
    input  logic                        line_start,
    output logic [CHAR_BITS-1:0]        code_char,
    output logic                        last_char
);

    localparam int unsigned DIFF_BITS = COORD_BITS + 1;

    logic [COORD_BITS-1:0] prev_lat_reg;
    logic [COORD_BITS-1:0] prev_lat_next;
    logic [COORD_BITS-1:0] prev_lon_reg;
    logic [COORD_BITS-1:0] prev_lon_next;
    logic [ZZ_BITS-1:0]    zz_reg;
    logic [ZZ_BITS-1:0]    zz_next;

    logic [COORD_BITS-1:0] prev_sel;
    logic [DIFF_BITS-1:0]  diff;
    logic [DIFF_BITS-1:0]  zigzag;
    logic [EXT_BITS-1:0]   zigzag_ext;
    logic                  more;
    logic [CHUNK_BITS:0]   chunk;

    // Pick the previous value of this axis, zero at the start of a line
    always_comb
    begin
        if (line_start)
        begin
            prev_sel = '0;
        end
        else if (axis)
        begin
            prev_sel = prev_lon_reg;
        end
        else
        begin
            prev_sel = prev_lat_reg;
        end
    end

    // Form the delta one bit wider, then zigzag it and cut to the chunk span
    assign diff       = {coordinate[COORD_BITS-1], coordinate}
                      - {prev_sel[COORD_BITS-1], prev_sel};
    assign zigzag     = {diff[DIFF_BITS-2:0], 1'b0} ^ {DIFF_BITS{diff[DIFF_BITS-1]}};
    assign zigzag_ext = {{(EXT_BITS-DIFF_BITS){1'b0}}, zigzag};

    // Update stored coordinates on load
    always_comb
    begin
        prev_lat_next = prev_lat_reg;
        prev_lon_next = prev_lon_reg;
        if (cmd.load)
        begin
            if (line_start)
            begin
                prev_lat_next = '0;
                prev_lon_next = '0;
            end
            if (axis)
            begin
                prev_lon_next = coordinate;
            end
            else
            begin
                prev_lat_next = coordinate;
            end
        end
    end

    // Load a fresh zigzag word or advance to the next chunk
    always_comb
    begin
        zz_next = zz_reg;
        if (cmd.load)
        begin
            zz_next = zigzag_ext[ZZ_BITS-1:0];
        end
        else if (cmd.shift)
        begin
            zz_next = zz_reg >> CHUNK_BITS;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_lat_reg <= '0;
            prev_lon_reg <= '0;
        end
        else
        begin
            prev_lat_reg <= prev_lat_next;
            prev_lon_reg <= prev_lon_next;
        end
    end

    // Payload register, no reset needed
    always_ff @(posedge clk)
    begin
        zz_reg <= zz_next;
    end

    // Build the character from the low chunk and the continuation flag
    assign more        = (zz_reg[ZZ_BITS-1:CHUNK_BITS] != '0);
    assign chunk       = {more, zz_reg[CHUNK_BITS-1:0]};
    assign code_char   = CHAR_BITS'(chunk) + CHAR_OFFSET;
    assign last_char   = !more;
    assign status.last = !more;

endmodule

/* hw/rtl/pce_ctrl.sv */
// ----------------------------------------------------------------------------
// pce_ctrl
// Sequences one coordinate at a time: load, then hand out one character
// word per cycle while the output is not stalled, until the final one is taken.
// ----------------------------------------------------------------------------
module pce_ctrl
    import pce_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    output logic        out_valid,
    input  logic        out_stall,
    output pce_cmd_t    cmd,
    input  pce_status_t status
);

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic out_take;
    logic done;
    logic in_ready;
    logic in_take;

    // Handshake decode; the last character frees the slot in the same cycle
    assign out_take  = (state_reg == ST_EMIT) && !out_stall;
    assign done      = out_take && status.last;
    assign in_ready  = (state_reg == ST_IDLE) || done;
    assign in_take   = in_valid && in_ready;
    assign in_stall  = !in_ready;
    assign out_valid = (state_reg == ST_EMIT);

    // Commands to the datapath
    assign cmd.load  = in_take;
    assign cmd.shift = out_take && !status.last;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (in_take)
                begin
                    state_next = ST_EMIT;
                end
                else if (done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state; out_valid is decoded straight from it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* hw/rtl/polyline_coordinate_encoder_top.sv */
// ----------------------------------------------------------------------------
// polyline_coordinate_encoder_top
// Encoded polyline character generator: one coordinate in, one to six
// ASCII characters out, delta-coded against the previous value of its axis.
//
//   Channel  Handshake            Word
//   -------  -------------------  ----------------------------------------
//   input    in_valid / in_stall  coordinate, axis, line_start
//   output   out_valid/out_stall  code_char, last_char
//
// A coordinate produces its characters one at a time, shifted out of the
// single zigzag register five bits per character.
// The next coordinate is taken in the cycle its predecessor's last
// character is taken, so with no output stall the output moves one word per
// cycle.
// Reset clears both stored coordinates to zero; no clearing pass is needed.
// A stall on the output holds the current character and stalls the input.
// ----------------------------------------------------------------------------
`include "polyline_coordinate_encoder_top_assert.svh"

module polyline_coordinate_encoder_top
    import pce_pkg::*;
#(
    parameter int unsigned COORD_BITS = 26
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [COORD_BITS-1:0] coordinate,
    input  logic                         axis,
    input  logic                         line_start,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [CHAR_BITS-1:0]         code_char,
    output logic                         last_char
);

    pce_cmd_t    cmd;
    pce_status_t status;

    // Controller
    pce_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    // Datapath
    pce_datapath #(
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .coordinate (coordinate),
        .axis       (axis),
        .line_start (line_start),
        .code_char  (code_char),
        .last_char  (last_char)
    );

    // An accepted coordinate always shows a character next cycle
    `PCE_ASSERT(a_load_then_emit, (in_valid && !in_stall) |=> out_valid, "no character after load")
    // Never take a coordinate while an unfinished one is still going out
    `PCE_ASSERT_NEVER(a_no_overlap, in_valid && !in_stall && out_valid && !(!out_stall && last_char), "coordinate taken during emit")
    // Continuation characters carry the flag, the final one does not
    `PCE_ASSERT(a_flag_match, out_valid |-> ((code_char >= 7'd95) == !last_char), "continuation flag mismatch")

endmodule
